>>> rtl/indexed_list_engine_core_macros.svh
// Assertion macros for the list engine.
// IMP: antecedent implies consequent in the same cycle.
// NXT checks that the antecedent implies the consequent in the next cycle.
`ifndef INDEXED_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ILE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ILE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ILE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/ile_pkg.sv
`timescale 1ns / 1ps
package ile_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int ST_W     = 2;
  localparam int FPOS_W   = 6;

  // request codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADIDX   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // probe kinds
  localparam logic [1:0] PK_READ  = 2'd0;
  localparam logic [1:0] PK_WRITE = 2'd1;
  localparam logic [1:0] PK_FIND  = 2'd2;

  // broadcast shift command to every cell
  typedef struct packed {
    logic              shift_up;
    logic              shift_dn;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] val;
  } cmd_t;

  // probe that walks the chain one cell per cycle
  typedef struct packed {
    logic              active;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    logic              found;
    logic [IDX_W-1:0]  fpos;
    logic [CNT_W-1:0]  limit;
  } probe_t;

endpackage

>>> rtl/ile_req_if.sv
`timescale 1ns / 1ps
interface ile_req_if;
  import ile_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position_in;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, op, position_in, data_in, input ready);
  modport sink (input valid, op, position_in, data_in, output ready);
endinterface

>>> rtl/ile_rsp_if.sv
`timescale 1ns / 1ps
interface ile_rsp_if;
  import ile_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] data_out;
  logic [FPOS_W-1:0] found_position;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, status, data_out, found_position, entry_count,
                  input ready);
  modport sink (input valid, status, data_out, found_position, entry_count,
                output ready);
endinterface

>>> rtl/ile_cell.sv
`timescale 1ns / 1ps
module ile_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ile_pkg::IDX_W-1:0]       index,
  input  ile_pkg::cmd_t                   cmd,
  input  logic [ile_pkg::DATA_W-1:0]      left_entry,
  input  logic [ile_pkg::DATA_W-1:0]      right_entry,
  output logic [ile_pkg::DATA_W-1:0]      entry,
  input  ile_pkg::probe_t                 probe_in,
  output ile_pkg::probe_t                 probe_out
);
  import ile_pkg::*;

  logic [CNT_W-1:0] idx_ext;
  logic             at_pos;
  logic             probe_here;
  probe_t           probe_next;

  assign idx_ext    = CNT_W'(index);
  assign at_pos     = (index == cmd.pos);
  assign probe_here = probe_in.active && (index == probe_in.pos);

  // update the held entry: shift from a neighbor or take a new word
  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (at_pos) begin
        entry <= cmd.val;
      end else if (index > cmd.pos && idx_ext <= cmd.cnt) begin
        entry <= left_entry;
      end
    end else if (cmd.shift_dn) begin
      if (index >= cmd.pos && (idx_ext + 1'b1) < cmd.cnt) begin
        entry <= right_entry;
      end
    end else if (probe_here && probe_in.kind == PK_WRITE) begin
      entry <= probe_in.data;
    end
  end

  // read, match or pass the probe on
  always_comb begin
    probe_next = probe_in;
    if (probe_here && probe_in.kind == PK_READ) begin
      probe_next.data = entry;
    end
    if (probe_in.active && probe_in.kind == PK_FIND && !probe_in.found &&
        idx_ext < probe_in.limit && entry == probe_in.data) begin
      probe_next.found = 1'b1;
      probe_next.fpos  = index;
    end
  end

  // advance the probe to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

>>> rtl/indexed_list_engine_core.sv
`timescale 1ns / 1ps
// Insert, append, remove, clear and any rejected request: result goes to a pending register
// at accept, then to the output register once that is free. Read, write and find wait for
// the probe walking the 64-cell chain one cell per clock; insert and remove shift at accept.
// One request at a time; the next is accepted once the result sits in the output register.
// Synchronous active-high rst clears the count and control state; entries stay undefined.
module indexed_list_engine_core (
  input  logic  clk,
  input  logic  rst,
  ile_req_if.sink   req,
  ile_rsp_if.source rsp
);
  import ile_pkg::*;
  `include "indexed_list_engine_core_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic              accept;

  logic [ST_W-1:0]   pend_status;
  logic [DATA_W-1:0] pend_data;
  logic [IDX_W-1:0]  pend_fpos;
  logic [CNT_W-1:0]  pend_count;

  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [DATA_W-1:0] out_data;
  logic [IDX_W-1:0]  out_fpos;
  logic [CNT_W-1:0]  out_count;

  cmd_t              cmd;
  probe_t            launch;
  logic [ST_W-1:0]   dec_status;
  logic [CNT_W-1:0]  dec_count;
  logic              dec_walk;
  logic              full;
  logic              load_out;

  logic [DATA_W-1:0] entries [CAPACITY];
  probe_t            probes [CAPACITY+1];
  probe_t            chain_out;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count >= CNT_W'(CAPACITY));
  assign chain_out = probes[CAPACITY];
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  // decode the request against the live count
  always_comb begin
    cmd          = '0;
    cmd.val      = req.data_in;
    cmd.cnt      = count;
    cmd.pos      = req.position_in[IDX_W-1:0];
    launch       = '0;
    launch.pos   = req.position_in[IDX_W-1:0];
    launch.data  = req.data_in;
    launch.limit = count;
    dec_status   = ST_OK;
    dec_count    = count;
    dec_walk     = 1'b0;
    unique case (req.op)
      OP_INSERT: begin
        if (req.position_in > POS_W'(count)) begin
          dec_status = ST_BADIDX;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          dec_count    = count + 1'b1;
        end
      end
      OP_APPEND: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          cmd.pos      = count[IDX_W-1:0];
          dec_count    = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (req.position_in >= POS_W'(count)) begin
          dec_status = ST_BADIDX;
        end else begin
          cmd.shift_dn = 1'b1;
          dec_count    = count - 1'b1;
        end
      end
      OP_READ, OP_WRITE: begin
        if (req.position_in >= POS_W'(count)) begin
          dec_status = ST_BADIDX;
        end else begin
          launch.active = 1'b1;
          launch.kind   = (req.op == OP_READ) ? PK_READ : PK_WRITE;
          dec_walk      = 1'b1;
        end
      end
      OP_FIND: begin
        launch.active = 1'b1;
        launch.kind   = PK_FIND;
        dec_walk      = 1'b1;
      end
      OP_CLEAR: begin
        dec_count = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.shift_up  = 1'b0;
      cmd.shift_dn  = 1'b0;
      launch.active = 1'b0;
      dec_walk      = 1'b0;
    end
  end

  assign probes[0] = launch;

  // chain of storage cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entries[g+1];
    end
    ile_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (IDX_W'(g)),
      .cmd         (cmd),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (entries[g]),
      .probe_in    (probes[g]),
      .probe_out   (probes[g+1])
    );
  end

  // sequence a request: decode, walk, hand to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count       <= dec_count;
        pend_status <= dec_status;
        pend_data   <= '0;
        pend_fpos   <= '0;
        pend_count  <= dec_count;
        state       <= dec_walk ? S_WALK : S_DONE;
      end
      if (state == S_WALK && chain_out.active) begin
        state <= S_DONE;
        if (chain_out.kind == PK_READ) begin
          pend_data <= chain_out.data;
        end
        if (chain_out.kind == PK_FIND) begin
          pend_status <= chain_out.found ? ST_OK : ST_NOTFOUND;
          pend_fpos   <= chain_out.found ? chain_out.fpos : '0;
        end
      end
      if (load_out) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_data   <= pend_data;
        out_fpos   <= pend_fpos;
        out_count  <= pend_count;
        state      <= S_IDLE;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.data_out       = out_data;
  assign rsp.found_position = FPOS_W'(out_fpos);
  assign rsp.entry_count    = out_count;

  `ILE_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CNT_W'(CAPACITY), "count over capacity")
  `ILE_ASSERT_IMP(a_probe_exit, clk, rst, chain_out.active, state == S_WALK, "stray probe")
  `ILE_ASSERT_NXT(a_walk_start, clk, rst, accept && dec_walk, state == S_WALK,
                  "walk not started")
  `ILE_ASSERT_IMP(a_nf_pos, clk, rst, rsp.valid && rsp.status == ST_NOTFOUND,
                  rsp.found_position == '0, "miss with position")

endmodule

>>> tb/indexed_list_engine_core_tb.sv
`timescale 1ns / 1ps
module indexed_list_engine_core_tb;
  import ile_pkg::*;

  // op code 7 carries no meaning; the block answers it with no change
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int POS_MAX      = (1 << POS_W) - 1;
  localparam int POOL_SIZE    = 8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } list_req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic [FPOS_W-1:0] fpos;
    logic [CNT_W-1:0]  count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ile_req_if req ();
  ile_rsp_if rsp ();

  indexed_list_engine_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #10 clk = ~clk;

  // mirror of the list contents and live count
  logic [DATA_W-1:0] list_vals [CAPACITY];
  int unsigned       list_len = 0;

  // stimulus side: words still to send and the count they will leave behind
  list_req_t         pending_reqs [$];
  int unsigned       gen_len = 0;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  list_rsp_t         expected_rsps [$];
  int                fail_count = 0;
  int                cycle_count = 0;
  int                req_idle = 0;
  int                rsp_stall = 0;
  list_req_t         next_req;
  list_req_t         sent_req;
  list_rsp_t         want_rsp;

  // apply one request to the mirror and return the result it must produce
  function automatic list_rsp_t apply_list_request(list_req_t r);
    list_rsp_t res;
    int        i;
    logic      hit;
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_INSERT: begin
        if (r.pos > list_len) begin
          res.status = ST_BADIDX;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > r.pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[r.pos] = r.data;
          list_len++;
        end
      end
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_vals[list_len] = r.data;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (r.pos >= list_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (i = r.pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (r.pos >= list_len) res.status = ST_BADIDX;
        else res.data = list_vals[r.pos];
      end
      OP_WRITE: begin
        if (r.pos >= list_len) res.status = ST_BADIDX;
        else list_vals[r.pos] = r.data;
      end
      OP_FIND: begin
        res.status = ST_NOTFOUND;
        hit = 1'b0;
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_vals[i] == r.data) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.fpos = i[FPOS_W-1:0];
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = list_len[CNT_W-1:0];
    return res;
  endfunction

  // queue a word and track the count it leaves behind
  function automatic void queue_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                        logic [DATA_W-1:0] data);
    list_req_t r;
    r.op = op;
    r.pos = pos;
    r.data = data;
    pending_reqs.push_back(r);
    case (op)
      OP_INSERT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
      OP_APPEND: if (gen_len < CAPACITY) gen_len++;
      OP_REMOVE: if (pos < gen_len) gen_len--;
      OP_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endfunction

  // mostly in range, often the upper end, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos(int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_W'($urandom_range(0, POS_MAX));
    if (r == 1) return POS_W'(top);
    return POS_W'($urandom_range(0, top));
  endfunction

  // favor a small pool so that finds hit and duplicates occur
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic int unsigned last_index();
    return (gen_len == 0) ? 0 : gen_len - 1;
  endfunction

  // grow the list to capacity through a mix of inserts and appends
  function automatic void queue_fill_to_full();
    while (gen_len < CAPACITY) begin
      if ($urandom_range(0, 1) == 0) queue_list_op(OP_INSERT,
                                                   POS_W'($urandom_range(0, gen_len)),
                                                   pick_value());
      else queue_list_op(OP_APPEND, POS_W'($urandom_range(0, POS_MAX)), pick_value());
    end
  endfunction

  // drive request words; hold them until accepted, predict on accept
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.op <= OP_INSERT;
      req.position_in <= '0;
      req.data_in <= '0;
      req_idle <= 0;
    end else begin
      if (req.valid && req.ready) begin
        sent_req.op = req.op;
        sent_req.pos = req.position_in;
        sent_req.data = req.data_in;
        expected_rsps.push_back(apply_list_request(sent_req));
      end
      if (!req.valid || req.ready) begin
        if (req_idle > 0) begin
          req.valid <= 1'b0;
          req_idle <= req_idle - 1;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req.valid <= 1'b1;
          req.op <= next_req.op;
          req.position_in <= next_req.pos;
          req.data_in <= next_req.data;
          if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
            req_idle <= $urandom_range(1, 5);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // accept result words with random stall bursts; compare against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
            fail_count++;
          end
          if (rsp.data_out !== want_rsp.data) begin
            $error("data_out: expected %h, got %h", want_rsp.data, rsp.data_out);
            fail_count++;
          end
          if (rsp.found_position !== want_rsp.fpos) begin
            $error("found_position: expected %0d, got %0d", want_rsp.fpos,
                   rsp.found_position);
            fail_count++;
          end
          if (rsp.entry_count !== want_rsp.count) begin
            $error("entry_count: expected %0d, got %0d", want_rsp.count, rsp.entry_count);
            fail_count++;
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp.ready <= 1'b0;
        rsp_stall <= rsp_stall - 1;
      end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        rsp_stall <= $urandom_range(0, 4);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned target;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < POOL_SIZE; k++) value_pool[k] = $urandom;

    // directed: empty-list rejects, front/end inserts, duplicates, ends of ranges
    queue_list_op(OP_READ,   0,   32'h0);
    queue_list_op(OP_REMOVE, 0,   32'h0);
    queue_list_op(OP_FIND,   0,   32'h0);
    queue_list_op(OP_INSERT, 1,   32'h1111_1111);
    queue_list_op(OP_INSERT, 0,   32'hFFFF_FFFF);
    queue_list_op(OP_INSERT, 0,   32'h0000_0000);
    queue_list_op(OP_INSERT, 2,   32'hA5A5_5A5A);
    queue_list_op(OP_APPEND, 0,   32'h0000_0000);
    queue_list_op(OP_FIND,   0,   32'h0000_0000);
    queue_list_op(OP_FIND,   0,   32'hFFFF_FFFF);
    queue_list_op(OP_FIND,   0,   32'h1234_5678);
    queue_list_op(OP_READ,   3,   32'h0);
    queue_list_op(OP_READ,   4,   32'h0);
    queue_list_op(OP_READ,   127, 32'h0);
    queue_list_op(OP_WRITE,  2,   32'h5A5A_A5A5);
    queue_list_op(OP_WRITE,  4,   32'hDEAD_BEEF);
    queue_list_op(OP_READ,   2,   32'h0);
    queue_list_op(OP_REMOVE, 3,   32'h0);
    queue_list_op(OP_REMOVE, 0,   32'h0);
    queue_list_op(OP_REMOVE, 64,  32'h0);
    queue_list_op(OP_UNUSED, 127, 32'hFFFF_FFFF);
    queue_list_op(OP_CLEAR,  127, 32'hFFFF_FFFF);
    queue_list_op(OP_READ,   0,   32'h0);

    // fill to capacity, then probe the full store: bad index wins over full
    target = pending_reqs.size() + RANDOM_ITEMS;
    queue_fill_to_full();
    queue_list_op(OP_INSERT, 64, pick_value());
    queue_list_op(OP_INSERT, 65, pick_value());
    queue_list_op(OP_APPEND, 0,  pick_value());
    queue_list_op(OP_READ,   63, 32'h0);
    queue_list_op(OP_FIND,   0,  value_pool[2]);
    queue_list_op(OP_REMOVE, 63, 32'h0);
    queue_list_op(OP_REMOVE, 0,  32'h0);

    // random mix; growth outweighs removal so the list spends time near full
    while (pending_reqs.size() < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 18) queue_list_op(OP_INSERT, pick_pos(gen_len), pick_value());
      else if (roll < 30) queue_list_op(OP_APPEND, pick_pos(POS_MAX), pick_value());
      else if (roll < 45) queue_list_op(OP_REMOVE, pick_pos(last_index()), pick_value());
      else if (roll < 62) queue_list_op(OP_READ, pick_pos(last_index()), pick_value());
      else if (roll < 75) queue_list_op(OP_WRITE, pick_pos(last_index()), pick_value());
      else if (roll < 93) queue_list_op(OP_FIND, pick_pos(POS_MAX), pick_value());
      else if (roll < 95) queue_list_op(OP_CLEAR, pick_pos(POS_MAX), pick_value());
      else if (roll < 97) queue_list_op(OP_UNUSED, pick_pos(POS_MAX), pick_value());
      else queue_fill_to_full();
    end

    // hold reset, then release on an edge
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // wait for every word to be sent and every result to return
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
